@@ rtl/text_mode_character_writer_top_macros.svh @@
// ----------------------------------------------------------------------------
// text mode character writer assertion macros
// shared concurrent assertion forms, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_CHARACTER_WRITER_TOP_MACROS_SVH
`define TEXT_MODE_CHARACTER_WRITER_TOP_MACROS_SVH
`ifndef SYNTH
// checked outside reset only
`define TMCW_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define TMCW_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMCW_ASSERT(name, prop, msg)
`define TMCW_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

@@ rtl/tmcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tmcw_pkg
// screen geometry, request and result types, control word and microprogram
// ----------------------------------------------------------------------------
package tmcw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    // power of two
    localparam int TAB_WIDTH   = 8;

    localparam int CELL_COUNT  = ROWS * COLUMNS;
    localparam int COPY_LAST   = (ROWS - 1) * COLUMNS - 1;
    localparam int CLEAR_START = (ROWS - 1) * COLUMNS;

    localparam int CUR_W  = $clog2(CELL_COUNT + 1);
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CNT_W  = $clog2(TAB_WIDTH + 1);
    localparam int STEP_W = 5;

    localparam logic [15:0] CURSOR_CELL = 16'h0720;
    localparam logic [7:0]  CARET_CHAR  = 8'h5e;
    localparam logic [7:0]  AT_CHAR     = 8'h40;
    localparam logic [7:0]  SPACE_CHAR  = 8'h20;
    localparam logic [7:0]  CTRL_LIMIT  = 8'h20;
    localparam logic [7:0]  ATTR_RESET  = 8'h07;

    localparam logic [8:0] CODE_NUL = 9'd0;
    localparam logic [8:0] CODE_TAB = 9'd9;
    localparam logic [8:0] CODE_NL  = 9'd10;
    localparam logic [8:0] CODE_CR  = 9'd13;
    localparam logic [8:0] CODE_BS  = 9'd256;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [8:0]  char_code;
        logic [10:0] cell_index;
    } req_t;

    typedef struct packed {
        logic [10:0] cursor_position;
        logic [15:0] cell_data;
    } rsp_t;

    typedef enum logic [2:0] {
        CUR_HOLD, CUR_INC, CUR_NEWLINE, CUR_CR, CUR_BACK, CUR_SCROLL
    } cur_op_t;

    typedef enum logic [1:0] {WR_NONE, WR_CHAR, WR_CURSOR, WR_ZERO} wr_sel_t;
    typedef enum logic [1:0] {CHR_CODE, CHR_CODE_AT, CHR_CARET, CHR_SPACE} chr_sel_t;
    typedef enum logic [1:0] {PTR_HOLD, PTR_INC, PTR_ZERO, PTR_CLEAR_START} ptr_op_t;

    typedef enum logic [2:0] {
        JMP_NEXT, JMP_GOTO, JMP_CALL, JMP_RET, JMP_DISP, JMP_WAIT, JMP_DONE
    } jump_t;

    typedef enum logic [2:0] {
        CND_ALWAYS, CND_SCROLL, CND_COPY_MORE, CND_CLEAR_MORE, CND_CNT_NZ
    } cond_t;

    typedef enum logic [2:0] {
        CLS_READ, CLS_NEWLINE, CLS_CR, CLS_BACK, CLS_TAB, CLS_ZERO, CLS_CTRL, CLS_PRINT
    } item_cls_t;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        cur_op_t  cur_op;
        wr_sel_t  wr_sel;
        chr_sel_t chr_sel;
        ptr_op_t  ptr_op;
        logic     cnt_load;
        logic     cnt_dec;
        logic     copy;
        logic     out_rdata;
    } ctrl_t;

    typedef struct packed {
        jump_t jmp;
        cond_t cond;
        step_t target;
        ctrl_t ctl;
    } ucode_t;

    typedef struct packed {
        logic      scroll;
        logic      copy_more;
        logic      clear_more;
        logic      cnt_nz;
        item_cls_t cls;
    } dp_stat_t;

    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    // flag bits of a control word: tab count load, tab count step, row copy, read data out
    localparam logic [3:0] F_NONE      = 4'b0000;
    localparam logic [3:0] F_CNT_LOAD  = 4'b1000;
    localparam logic [3:0] F_CNT_DEC   = 4'b0100;
    localparam logic [3:0] F_COPY      = 4'b0010;
    localparam logic [3:0] F_OUT_RDATA = 4'b0001;

    // microprogram step addresses
    localparam step_t S_INIT  = 5'd0;
    localparam step_t S_IDLE  = 5'd1;
    localparam step_t S_DISP  = 5'd2;
    localparam step_t S_RDONE = 5'd3;
    localparam step_t S_NL    = 5'd4;
    localparam step_t S_CR    = 5'd5;
    localparam step_t S_BS    = 5'd6;
    localparam step_t S_PR    = 5'd7;
    localparam step_t S_C1    = 5'd8;
    localparam step_t S_C2    = 5'd9;
    localparam step_t S_C3    = 5'd10;
    localparam step_t S_T0    = 5'd11;
    localparam step_t S_T1    = 5'd12;
    localparam step_t S_T2    = 5'd13;
    localparam step_t S_T3    = 5'd14;
    localparam step_t S_TAIL  = 5'd15;
    localparam step_t S_CCELL = 5'd16;
    localparam step_t S_PDONE = 5'd17;
    localparam step_t S_SC0   = 5'd18;
    localparam step_t S_SC1   = 5'd19;
    localparam step_t S_SC2   = 5'd20;
    localparam step_t S_SC3   = 5'd21;
    localparam step_t S_SC4   = 5'd22;

    function automatic ucode_t mk(jump_t j, cond_t c, step_t t, cur_op_t co, wr_sel_t w,
                                  chr_sel_t ch, ptr_op_t p, logic [3:0] fl);
        ucode_t u;
        u.jmp           = j;
        u.cond          = c;
        u.target        = t;
        u.ctl.cur_op    = co;
        u.ctl.wr_sel    = w;
        u.ctl.chr_sel   = ch;
        u.ctl.ptr_op    = p;
        u.ctl.cnt_load  = fl[3];
        u.ctl.cnt_dec   = fl[2];
        u.ctl.copy      = fl[1];
        u.ctl.out_rdata = fl[0];
        return u;
    endfunction

    function automatic ucode_t ucode_rom(step_t pc);
        ucode_t u;
        case (pc)
            // clearing pass after reset
            S_INIT:  u = mk(JMP_GOTO, CND_CLEAR_MORE, S_INIT, CUR_HOLD, WR_ZERO, CHR_CODE,
                            PTR_INC, F_NONE);
            S_IDLE:  u = mk(JMP_WAIT, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_DISP:  u = mk(JMP_DISP, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_RDONE: u = mk(JMP_DONE, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_OUT_RDATA);
            S_NL:    u = mk(JMP_GOTO, CND_ALWAYS, S_TAIL, CUR_NEWLINE, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_CR:    u = mk(JMP_GOTO, CND_ALWAYS, S_PDONE, CUR_CR, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_BS:    u = mk(JMP_GOTO, CND_ALWAYS, S_TAIL, CUR_BACK, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_PR:    u = mk(JMP_GOTO, CND_ALWAYS, S_TAIL, CUR_INC, WR_CHAR, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_C1:    u = mk(JMP_NEXT, CND_ALWAYS, S_IDLE, CUR_INC, WR_CHAR, CHR_CARET,
                            PTR_HOLD, F_NONE);
            S_C2:    u = mk(JMP_CALL, CND_SCROLL, S_SC0, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_C3:    u = mk(JMP_GOTO, CND_ALWAYS, S_TAIL, CUR_INC, WR_CHAR, CHR_CODE_AT,
                            PTR_HOLD, F_NONE);
            S_T0:    u = mk(JMP_NEXT, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_CNT_LOAD);
            S_T1:    u = mk(JMP_NEXT, CND_ALWAYS, S_IDLE, CUR_INC, WR_CHAR, CHR_SPACE,
                            PTR_HOLD, F_CNT_DEC);
            S_T2:    u = mk(JMP_CALL, CND_SCROLL, S_SC0, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_T3:    u = mk(JMP_GOTO, CND_CNT_NZ, S_T1, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_TAIL:  u = mk(JMP_CALL, CND_SCROLL, S_SC0, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_CCELL: u = mk(JMP_NEXT, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_CURSOR, CHR_CODE,
                            PTR_HOLD, F_NONE);
            S_PDONE: u = mk(JMP_DONE, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            // scroll subroutine: copy rows up, clear the bottom row, return
            S_SC0:   u = mk(JMP_NEXT, CND_ALWAYS, S_IDLE, CUR_SCROLL, WR_NONE, CHR_CODE,
                            PTR_ZERO, F_NONE);
            S_SC1:   u = mk(JMP_GOTO, CND_COPY_MORE, S_SC1, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_INC, F_COPY);
            // lets the last copied cell land
            S_SC2:   u = mk(JMP_NEXT, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_CLEAR_START, F_NONE);
            S_SC3:   u = mk(JMP_GOTO, CND_CLEAR_MORE, S_SC3, CUR_HOLD, WR_ZERO, CHR_CODE,
                            PTR_INC, F_NONE);
            S_SC4:   u = mk(JMP_RET, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
            default: u = mk(JMP_GOTO, CND_ALWAYS, S_IDLE, CUR_HOLD, WR_NONE, CHR_CODE,
                            PTR_HOLD, F_NONE);
        endcase
        return u;
    endfunction

    function automatic step_t entry_of(item_cls_t cls);
        step_t s;
        case (cls)
            CLS_READ:    s = S_RDONE;
            CLS_NEWLINE: s = S_NL;
            CLS_CR:      s = S_CR;
            CLS_BACK:    s = S_BS;
            CLS_TAB:     s = S_T0;
            CLS_ZERO:    s = S_TAIL;
            CLS_CTRL:    s = S_C1;
            default:     s = S_PR;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/tmcw_sequencer.sv @@
// ----------------------------------------------------------------------------
// tmcw_sequencer
// step counter over the microprogram rom, with conditional jumps, one-level
// call and return, dispatch on the request class and the wait/done handshakes
// ----------------------------------------------------------------------------
module tmcw_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 out_free,
    input  tmcw_pkg::dp_stat_t   stat,
    output tmcw_pkg::ctrl_t      ctl,
    output tmcw_pkg::seq_stat_t  sstat
);
    import tmcw_pkg::*;

    step_t  pc_reg, pc_next;
    step_t  ret_reg, ret_next;
    step_t  pc_inc;
    ucode_t uw;
    logic   cond_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= S_INIT;
            ret_reg <= S_IDLE;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

    always_comb
    begin
        uw     = ucode_rom(pc_reg);
        pc_inc = pc_reg + step_t'(1);

        case (uw.cond)
            CND_ALWAYS:     cond_ok = 1'b1;
            CND_SCROLL:     cond_ok = stat.scroll;
            CND_COPY_MORE:  cond_ok = stat.copy_more;
            CND_CLEAR_MORE: cond_ok = stat.clear_more;
            CND_CNT_NZ:     cond_ok = stat.cnt_nz;
            default:        cond_ok = 1'b0;
        endcase

        ret_next = ret_reg;
        case (uw.jmp)
            JMP_NEXT: pc_next = pc_inc;
            JMP_GOTO: pc_next = cond_ok ? uw.target : pc_inc;
            JMP_CALL:
            begin
                pc_next = cond_ok ? uw.target : pc_inc;
                if (cond_ok)
                begin
                    ret_next = pc_inc;
                end
            end
            JMP_RET:  pc_next = ret_reg;
            JMP_DISP: pc_next = entry_of(stat.cls);
            JMP_WAIT: pc_next = start ? S_DISP : pc_reg;
            JMP_DONE: pc_next = out_free ? S_IDLE : pc_reg;
            default:  pc_next = S_IDLE;
        endcase

        ctl        = uw.ctl;
        sstat.idle = (uw.jmp == JMP_WAIT);
        sstat.done = (uw.jmp == JMP_DONE) && out_free;
    end

endmodule

@@ rtl/tmcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tmcw_datapath
// screen memory, cursor and column, tab count and sweep pointer, driven by the
// control word of the current step, and the request register, taken on load
// ----------------------------------------------------------------------------
`include "text_mode_character_writer_top_macros.svh"

module tmcw_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tmcw_pkg::req_t      req,
    input  logic [7:0]          attr,
    input  tmcw_pkg::ctrl_t     ctl,
    output tmcw_pkg::dp_stat_t  stat,
    output tmcw_pkg::rsp_t      rsp
);
    import tmcw_pkg::*;

    logic [15:0]       mem [CELL_COUNT];

    req_t              item_reg;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CUR_W-1:0]  ptr_reg, ptr_next;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;
    logic [15:0]       rdata_reg;

    logic              idx_ok;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [7:0]        chr;
    logic [7:0]        low_byte;
    logic [CUR_W-1:0]  tab_phase;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= req;
        end
        pend_addr_reg <= ADDR_W'(ptr_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            col_reg    <= '0;
            cnt_reg    <= '0;
            ptr_reg    <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            cnt_reg    <= cnt_next;
            ptr_reg    <= ptr_next;
            pend_reg   <= ctl.copy;
        end
    end

    // screen memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        low_byte  = item_reg.char_code[7:0];
        idx_ok    = int'(item_reg.cell_index) < CELL_COUNT;
        tab_phase = cursor_reg & CUR_W'(TAB_WIDTH - 1);

        // row copy reads one row ahead of the write pointer
        if (ctl.copy)
        begin
            raddr = ADDR_W'(ptr_reg + CUR_W'(COLUMNS));
        end
        else
        begin
            raddr = idx_ok ? ADDR_W'(item_reg.cell_index) : '0;
        end

        case (ctl.chr_sel)
            CHR_CODE:    chr = low_byte;
            CHR_CODE_AT: chr = low_byte + AT_CHAR;
            CHR_CARET:   chr = CARET_CHAR;
            CHR_SPACE:   chr = SPACE_CHAR;
            default:     chr = low_byte;
        endcase

        we    = 1'b0;
        waddr = ADDR_W'(cursor_reg);
        wdata = '0;
        if (pend_reg)
        begin
            we    = 1'b1;
            waddr = pend_addr_reg;
            wdata = rdata_reg;
        end
        else
        begin
            case (ctl.wr_sel)
                WR_NONE:   we = 1'b0;
                WR_CHAR:
                begin
                    we    = 1'b1;
                    wdata = {attr, chr};
                end
                WR_CURSOR:
                begin
                    we    = 1'b1;
                    wdata = CURSOR_CELL;
                end
                WR_ZERO:
                begin
                    we    = 1'b1;
                    waddr = ADDR_W'(ptr_reg);
                end
                default:   we = 1'b0;
            endcase
        end

        cursor_next = cursor_reg;
        col_next    = col_reg;
        case (ctl.cur_op)
            CUR_HOLD: cursor_next = cursor_reg;
            CUR_INC:
            begin
                cursor_next = cursor_reg + CUR_W'(1);
                col_next    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + COL_W'(1);
            end
            CUR_NEWLINE:
            begin
                cursor_next = cursor_reg + CUR_W'(COLUMNS) - CUR_W'(col_reg);
                col_next    = '0;
            end
            CUR_CR:
            begin
                cursor_next = cursor_reg - CUR_W'(col_reg);
                col_next    = '0;
            end
            CUR_BACK:
            begin
                if (cursor_reg != '0)
                begin
                    cursor_next = cursor_reg - CUR_W'(1);
                    col_next    = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - COL_W'(1);
                end
            end
            CUR_SCROLL: cursor_next = cursor_reg - CUR_W'(COLUMNS);
            default:    cursor_next = cursor_reg;
        endcase

        cnt_next = cnt_reg;
        if (ctl.cnt_load)
        begin
            cnt_next = CNT_W'(TAB_WIDTH) - CNT_W'(tab_phase);
        end
        else if (ctl.cnt_dec)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end

        case (ctl.ptr_op)
            PTR_HOLD:        ptr_next = ptr_reg;
            PTR_INC:         ptr_next = ptr_reg + CUR_W'(1);
            PTR_ZERO:        ptr_next = '0;
            PTR_CLEAR_START: ptr_next = CUR_W'(CLEAR_START);
            default:         ptr_next = ptr_reg;
        endcase

        stat.scroll     = cursor_reg >= CUR_W'(CELL_COUNT);
        stat.copy_more  = ptr_reg != CUR_W'(COPY_LAST);
        stat.clear_more = ptr_reg != CUR_W'(CELL_COUNT - 1);
        stat.cnt_nz     = cnt_reg != '0;

        if (item_reg.operation == OP_READ)
        begin
            stat.cls = CLS_READ;
        end
        else if (item_reg.char_code == CODE_NL)
        begin
            stat.cls = CLS_NEWLINE;
        end
        else if (item_reg.char_code == CODE_CR)
        begin
            stat.cls = CLS_CR;
        end
        else if (item_reg.char_code == CODE_BS)
        begin
            stat.cls = CLS_BACK;
        end
        else if (item_reg.char_code == CODE_TAB)
        begin
            stat.cls = CLS_TAB;
        end
        else if (item_reg.char_code == CODE_NUL)
        begin
            stat.cls = CLS_ZERO;
        end
        else if (low_byte < CTRL_LIMIT)
        begin
            stat.cls = CLS_CTRL;
        end
        else
        begin
            stat.cls = CLS_PRINT;
        end

        rsp.cursor_position = 11'(cursor_reg);
        rsp.cell_data       = (ctl.out_rdata && idx_ok) ? rdata_reg : '0;
    end

    `TMCW_ASSERT(a_cursor_write_in_range, (ctl.wr_sel == WR_CHAR || ctl.wr_sel == WR_CURSOR) |-> (cursor_reg < CUR_W'(CELL_COUNT)), "cursor cell write beyond screen")
    `TMCW_ASSERT(a_copy_no_port_clash, pend_reg |-> (ctl.wr_sel == WR_NONE), "row copy write collides with step write")
    `TMCW_ASSERT(a_col_range, int'(col_reg) < COLUMNS, "column counter out of range")

endmodule

@@ rtl/text_mode_character_writer_top.sv @@
// ----------------------------------------------------------------------------
// text_mode_character_writer_top
// 80x25 text screen with cursor, put and read requests, microcoded control
// ----------------------------------------------------------------------------
// requests come in on req (valid/stall); each gives one result on rsp
// (valid/stall) with the cursor after the request and, for a read, the cell
// a put interprets one character, a read returns one cell of the screen
// text_attribute is written over cfg (valid/ready, always ready); the user must
// write it only while idle, a rule that the block itself leaves unenforced
// a put that runs past the last row scrolls: rows are copied up, then the
// bottom row is cleared, one cell per cycle through the one write port of
// the screen memory
// one request at a time: req_stall stays high until the step counter is idle
// after reset the screen memory is cleared one cell per cycle with
// req_stall high; cursor is 0 and the attribute 7
// a stalled result is held in the output register; the request after it is
// taken and worked on, and waits at its last step until the register frees
// ----------------------------------------------------------------------------
`include "text_mode_character_writer_top_macros.svh"

module text_mode_character_writer_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  tmcw_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tmcw_pkg::rsp_t  rsp,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_data
);
    import tmcw_pkg::*;

    logic       cfg_write;
    logic [7:0] text_attribute_reg;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_t       rsp_reg;
    rsp_t       dp_rsp;
    ctrl_t      ctl;
    seq_stat_t  sstat;
    dp_stat_t   stat;
    logic       accept;
    logic       out_free;

    assign cfg_ready = 1'b1;
    assign req_stall = !sstat.idle;
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign cfg_write = cfg_valid && cfg_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_attribute_reg <= ATTR_RESET;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                text_attribute_reg <= cfg_data;
            end
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sstat.done)
        begin
            rsp_reg <= dp_rsp;
        end
    end

    always_comb
    begin
        if (sstat.done)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    tmcw_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .out_free (out_free),
        .stat     (stat),
        .ctl      (ctl),
        .sstat    (sstat)
    );

    tmcw_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept),
        .req   (req),
        .attr  (text_attribute_reg),
        .ctl   (ctl),
        .stat  (stat),
        .rsp   (dp_rsp)
    );

    `TMCW_ASSERT(a_accept_leaves_idle, accept |=> !sstat.idle, "sequencer stayed idle after a request")
    `TMCW_ASSERT(a_done_needs_room, sstat.done |-> (!rsp_valid_reg || !rsp_stall), "result loaded over a held result")
    `TMCW_ASSERT(a_idle_after_done, sstat.done |=> sstat.idle, "sequencer not idle after result")

endmodule
